/* hw/rtl/pqnce_pkg.sv */
`timescale 1ns / 1ps

package pqnce_pkg;

  localparam int SUBSPACES  = 8;
  localparam int CODEWORDS  = 16;
  localparam int SUB_DIM    = 8;
  localparam int ELEMS      = 8;
  localparam int ZERO_POINT = 128;

  localparam int DEPTH   = SUBSPACES * CODEWORDS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(CODEWORDS);
  localparam int SUB_W   = 3;
  localparam int IDX_W   = 4;
  localparam int ELEM_W  = 8;
  localparam int NORM_W  = 18;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int DOT_W   = PROD_W + $clog2(ELEMS);
  localparam int SCORE_W = 20;
  localparam int WORD_W  = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [ELEMS-1:0][ELEM_W-1:0] vec_t;

  typedef struct packed {
    vec_t              code;
    logic [NORM_W-1:0] norm;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QUERY,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             busy;
    logic             ld_go;
    logic             rd_go;
    logic [CNT_W-1:0] rd_k;
    logic             finish;
  } ctl_t;

endpackage

/* hw/rtl/pqnce_store.sv */
`timescale 1ns / 1ps

module pqnce_store (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    we,
  input  logic [pqnce_pkg::ADDR_W-1:0] waddr,
  input  pqnce_pkg::entry_t       wdata,
  input  logic                    re,
  input  logic [pqnce_pkg::ADDR_W-1:0] raddr,
  output pqnce_pkg::entry_t       rdata,
  output logic                    rvalid
);
  import pqnce_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;
  logic   rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= re;
    end
  end

  assign rdata  = rdata_r;
  assign rvalid = rvalid_r;

endmodule

/* hw/rtl/pqnce_mac.sv */
`timescale 1ns / 1ps

module pqnce_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  input  pqnce_pkg::vec_t               a,
  input  pqnce_pkg::vec_t               b,
  input  logic [pqnce_pkg::NORM_W-1:0]  aux,
  output logic                          busy,
  output logic                          sum_v,
  output logic signed [pqnce_pkg::DOT_W-1:0] dot,
  output logic [pqnce_pkg::NORM_W-1:0]  sum_aux
);
  import pqnce_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [ELEMS];
  logic signed [PROD_W-1:0] prod_nxt [ELEMS];
  logic [NORM_W-1:0]        aux_p_r;
  logic                     prod_v_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [DOT_W-1:0]  dot_nxt;
  logic [NORM_W-1:0]        aux_s_r;
  logic                     sum_v_r;

  for (genvar d = 0; d < ELEMS; d++) begin : g_mul
    if (d < SUB_DIM) begin : g_on
      assign prod_nxt[d] = $signed(a[d]) * $signed(b[d]);
    end else begin : g_off
      assign prod_nxt[d] = '0;
    end
  end

  always_comb begin
    dot_nxt = '0;
    for (int d = 0; d < ELEMS; d++) begin
      dot_nxt = dot_nxt + DOT_W'(prod_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      prod_r  <= prod_nxt;
      aux_p_r <= aux;
    end
    if (prod_v_r) begin
      dot_r   <= dot_nxt;
      aux_s_r <= aux_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
    end else begin
      prod_v_r <= in_v;
      sum_v_r  <= prod_v_r;
    end
  end

  assign busy    = prod_v_r | sum_v_r;
  assign sum_v   = sum_v_r;
  assign dot     = dot_r;
  assign sum_aux = aux_s_r;

endmodule

/* hw/rtl/pqnce_ctrl.sv */
`timescale 1ns / 1ps

module pqnce_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        kind,
  input  logic [pqnce_pkg::SUB_W-1:0] sub_index,
  input  logic [pqnce_pkg::IDX_W-1:0] code_index,
  input  logic                        pipe_busy,
  output pqnce_pkg::ctl_t             ctl
);
  import pqnce_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] k_nxt;
  logic             accept;
  logic             sub_ok;
  logic             code_ok;

  assign accept  = start && (state_r == ST_IDLE);
  assign sub_ok  = 32'(sub_index) < SUBSPACES;
  assign code_ok = 32'(code_index) < CODEWORDS;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && sub_ok) begin
          if (kind == KIND_QUERY) begin
            state_nxt = ST_QUERY;
          end else if (code_ok) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DRAIN;
      end
      ST_QUERY: begin
        if (k_r == CNT_W'(CODEWORDS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (accept) begin
      k_nxt = '0;
    end else if (state_r == ST_QUERY) begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.rd_k   = k_r;
    unique case (state_r)
      ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      ST_LOAD: begin
        ctl.busy  = 1'b1;
        ctl.ld_go = 1'b1;
      end
      ST_QUERY: begin
        ctl.busy  = 1'b1;
        ctl.rd_go = 1'b1;
      end
      ST_DRAIN: begin
        ctl.busy   = 1'b1;
        ctl.finish = !pipe_busy;
      end
      default: ctl.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* hw/rtl/pq_nearest_codeword_encoder.sv */
`timescale 1ns / 1ps

// Product-quantization encoder. A request with in_kind low loads one signed
// codeword and its squared norm into the subspace codebook and gives no result.
// A request with in_kind high scores all 16 codewords of its subspace as norm
// minus twice the dot product with the latent bytes (offset by 128) and returns
// the lowest score, lowest index on a tie. One shared eight-lane multiply and
// sum unit scores one codeword per cycle from the single read port of the
// codebook memory, so a query holds busy until all its codewords are scored,
// and its result appears with out_valid for one cycle right after.
// Results cannot be stalled; the next request may be taken in that cycle.
// Codewords must be loaded before they are queried.
module pq_nearest_codeword_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic [pqnce_pkg::SUB_W-1:0]          in_sub_index,
  input  logic [pqnce_pkg::IDX_W-1:0]          in_code_index,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem0,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem1,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem2,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem3,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem4,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem5,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem6,
  input  logic [pqnce_pkg::ELEM_W-1:0]         in_elem7,
  output logic                                 out_valid,
  output logic [pqnce_pkg::IDX_W-1:0]          out_best_index,
  output logic signed [pqnce_pkg::SCORE_W-1:0] out_best_score,
  output logic [pqnce_pkg::WORD_W-1:0]         out_packed_word,
  output logic                                 out_word_done
);
  import pqnce_pkg::*;

  ctl_t                      ctl;
  logic                      accept;
  logic                      kind_r;
  logic [SUB_W-1:0]          sub_r;
  logic [IDX_W-1:0]          code_r;
  vec_t                      elem_r;
  vec_t                      lat;
  vec_t                      mac_a;
  vec_t                      mac_b;
  entry_t                    rd_data;
  entry_t                    wr_data;
  logic                      rd_valid;
  logic                      mac_busy;
  logic                      sum_v;
  logic signed [DOT_W-1:0]   dot;
  logic [NORM_W-1:0]         sum_norm;
  logic                      mem_we;
  logic [ADDR_W-1:0]         waddr;
  logic [ADDR_W-1:0]         raddr;
  logic signed [SCORE_W:0]   score_wide;
  logic signed [SCORE_W-1:0] score;
  logic                      take;
  logic [CNT_W-1:0]          cmp_k_r;
  logic [CNT_W-1:0]          best_k_r;
  logic signed [SCORE_W-1:0] best_r;
  logic [WORD_W-1:0]         idx_word_r;
  logic [WORD_W-1:0]         word_nxt;
  logic                      last_sub;
  logic                      report;
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_index_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [WORD_W-1:0]         out_word_r;
  logic                      out_done_r;

  assign accept = start && !ctl.busy;
  assign busy   = ctl.busy;

  pqnce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_kind),
    .sub_index  (in_sub_index),
    .code_index (in_code_index),
    .pipe_busy  (rd_valid | mac_busy),
    .ctl        (ctl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      sub_r  <= in_sub_index;
      code_r <= in_code_index;
      elem_r <= {in_elem7, in_elem6, in_elem5, in_elem4,
                 in_elem3, in_elem2, in_elem1, in_elem0};
    end
  end

  for (genvar d = 0; d < ELEMS; d++) begin : g_lat
    logic [ELEM_W:0] diff;
    assign diff   = {1'b0, elem_r[d]} - (ELEM_W + 1)'(ZERO_POINT);
    assign lat[d] = diff[ELEM_W-1:0];
  end

  assign raddr = ADDR_W'(int'(sub_r) * CODEWORDS + int'(ctl.rd_k));
  assign waddr = ADDR_W'(int'(sub_r) * CODEWORDS + int'(code_r));

  assign mem_we       = sum_v && (kind_r == KIND_LOAD);
  assign wr_data.code = elem_r;
  assign wr_data.norm = NORM_W'(dot);

  pqnce_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (mem_we),
    .waddr  (waddr),
    .wdata  (wr_data),
    .re     (ctl.rd_go),
    .raddr  (raddr),
    .rdata  (rd_data),
    .rvalid (rd_valid)
  );

  assign mac_a = (kind_r == KIND_QUERY) ? lat : elem_r;
  assign mac_b = (kind_r == KIND_QUERY) ? rd_data.code : elem_r;

  pqnce_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (ctl.ld_go | rd_valid),
    .a       (mac_a),
    .b       (mac_b),
    .aux     (rd_data.norm),
    .busy    (mac_busy),
    .sum_v   (sum_v),
    .dot     (dot),
    .sum_aux (sum_norm)
  );

  assign score_wide = $signed({{(SCORE_W + 1 - NORM_W){1'b0}}, sum_norm})
                    - ($signed({{(SCORE_W + 1 - DOT_W){dot[DOT_W-1]}}, dot}) <<< 1);
  assign score      = score_wide[SCORE_W-1:0];
  assign take       = (cmp_k_r == '0) || (score < best_r);

  always_ff @(posedge clk) begin
    if (sum_v && (kind_r == KIND_QUERY) && take) begin
      best_r   <= score;
      best_k_r <= cmp_k_r;
    end
  end

  assign last_sub = sub_r == SUB_W'(SUBSPACES - 1);
  assign word_nxt = idx_word_r | (WORD_W'(best_k_r) << {sub_r, 2'b00});
  assign report   = ctl.finish && (kind_r == KIND_QUERY);

  always_ff @(posedge clk) begin
    if (report) begin
      out_index_r <= IDX_W'(best_k_r);
      out_score_r <= best_r;
      out_word_r  <= word_nxt;
      out_done_r  <= last_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_k_r     <= '0;
      idx_word_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= report;
      if (accept) begin
        cmp_k_r <= '0;
      end else if (sum_v && (kind_r == KIND_QUERY)) begin
        cmp_k_r <= cmp_k_r + 1'b1;
      end
      if (report) begin
        idx_word_r <= last_sub ? '0 : word_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_index  = out_index_r;
  assign out_best_score  = out_score_r;
  assign out_packed_word = out_word_r;
  assign out_word_done   = out_done_r;

  a_pipe_under_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid || mac_busy) |-> ctl.busy)
    else $error("Scoring pipeline active while the block reports idle.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid))
    else $error("Result strobe held for more than one cycle.");

  a_word_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (report && last_sub) |=> (idx_word_r == '0))
    else $error("Packed word not cleared after the last subspace.");

  a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_go |-> !mem_we)
    else $error("Codebook written while a query is reading it.");

endmodule

/* tb/sv/tb_pq_nearest_codeword_encoder.sv */
`timescale 1ns / 1ps

module tb_pq_nearest_codeword_encoder;
  import pqnce_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MIXED_REQUESTS = 420;

  typedef struct packed {
    logic             kind;
    logic [SUB_W-1:0] sub;
    logic [IDX_W-1:0] code;
    vec_t             elems;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]          best_index;
    logic signed [SCORE_W-1:0] best_score;
    logic [WORD_W-1:0]         packed_word;
    logic                      word_done;
  } match_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    match_t   want;
  } vector_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_kind;
  logic [SUB_W-1:0]          in_sub_index;
  logic [IDX_W-1:0]          in_code_index;
  vec_t                      in_elems;
  logic                      out_valid;
  logic [IDX_W-1:0]          out_best_index;
  logic signed [SCORE_W-1:0] out_best_score;
  logic [WORD_W-1:0]         out_packed_word;
  logic                      out_word_done;

  vec_t              codebook [DEPTH];
  int unsigned       norm_table [DEPTH];
  bit                written [DEPTH];
  logic [WORD_W-1:0] packed_acc;

  match_t      pending_matches[$];
  vector_row_t directed_rows[$];
  int          errors = 0;
  int          stall_cycles = 0;

  pq_nearest_codeword_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_sub_index   (in_sub_index),
    .in_code_index  (in_code_index),
    .in_elem0       (in_elems[0]),
    .in_elem1       (in_elems[1]),
    .in_elem2       (in_elems[2]),
    .in_elem3       (in_elems[3]),
    .in_elem4       (in_elems[4]),
    .in_elem5       (in_elems[5]),
    .in_elem6       (in_elems[6]),
    .in_elem7       (in_elems[7]),
    .out_valid      (out_valid),
    .out_best_index (out_best_index),
    .out_best_score (out_best_score),
    .out_packed_word(out_packed_word),
    .out_word_done  (out_word_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic request_t make_request(logic kind, logic [SUB_W-1:0] sub,
                                            logic [IDX_W-1:0] code, vec_t elems);
    request_t r;
    r.kind  = kind;
    r.sub   = sub;
    r.code  = code;
    r.elems = elems;
    return r;
  endfunction

  function automatic match_t make_match(int idx, int score, logic [WORD_W-1:0] word,
                                        logic done);
    match_t m;
    m.best_index  = IDX_W'(idx);
    m.best_score  = SCORE_W'(score);
    m.packed_word = word;
    m.word_done   = done;
    return m;
  endfunction

  task automatic add_row(request_t r, logic typed, match_t want);
    vector_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [ELEM_W-1:0] rand_byte();
    case ($urandom_range(0, 19))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return ELEM_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic vec_t random_elems();
    vec_t v;
    for (int d = 0; d < ELEMS; d++) v[d] = rand_byte();
    return v;
  endfunction

  // A codeword sometimes duplicates a neighbor so that ties show up in the search.
  function automatic vec_t codeword_for(logic [SUB_W-1:0] sub);
    int unsigned peer;
    peer = sub * CODEWORDS + $urandom_range(0, CODEWORDS - 1);
    if (written[peer] && $urandom_range(0, 99) < 15) return codebook[peer];
    return random_elems();
  endfunction

  function automatic int gap_cycles(int n);
    int pick;
    if (n % 100 < 15) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 45);
  endfunction

  task automatic encode_request(input request_t r, output bit has_result,
                                output match_t m);
    int unsigned slot;
    int          d;
    int          k;
    int          v;
    int          dot;
    int          score;
    int          best;
    int          best_k;
    has_result = 1'b0;
    m = '0;
    if (r.kind == KIND_LOAD) begin
      slot = r.sub * CODEWORDS + r.code;
      codebook[slot] = r.elems;
      written[slot]  = 1'b1;
      dot = 0;
      for (d = 0; d < SUB_DIM; d++) begin
        v = int'($signed(r.elems[d]));
        dot += v * v;
      end
      norm_table[slot] = dot & ((1 << NORM_W) - 1);
    end else begin
      best   = 32'h7FFF_FFFF;
      best_k = 0;
      for (k = 0; k < CODEWORDS; k++) begin
        slot = r.sub * CODEWORDS + k;
        dot  = 0;
        for (d = 0; d < SUB_DIM; d++) begin
          v = int'($signed(codebook[slot][d]));
          dot += (int'(r.elems[d]) - ZERO_POINT) * v;
        end
        score = int'(norm_table[slot]) - 2 * dot;
        if (score < best) begin
          best   = score;
          best_k = k;
        end
      end
      packed_acc = packed_acc | (WORD_W'(best_k) << (IDX_W * r.sub));
      m.best_index  = IDX_W'(best_k);
      m.best_score  = SCORE_W'(best);
      m.packed_word = packed_acc;
      m.word_done   = (r.sub == SUBSPACES - 1);
      if (m.word_done) packed_acc = '0;
      has_result = 1'b1;
    end
  endtask

  task automatic send_request(request_t r, logic typed, match_t want);
    bit     has_result;
    match_t m;
    start         <= 1'b1;
    in_kind       <= r.kind;
    in_sub_index  <= r.sub;
    in_code_index <= r.code;
    in_elems      <= r.elems;
    @(posedge clk);
    while (busy) @(posedge clk);
    encode_request(r, has_result, m);
    if (has_result) pending_matches.push_back(typed ? want : m);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  initial begin
    request_t         r;
    match_t           none;
    vec_t             cw;
    logic [SUB_W-1:0] sub;
    logic [IDX_W-1:0] code;
    int               k;
    int               n;
    int               next_sub;
    start         <= 1'b0;
    rst_n         <= 1'b0;
    in_kind       <= KIND_LOAD;
    in_sub_index  <= '0;
    in_code_index <= '0;
    in_elems      <= '0;
    packed_acc = '0;
    none = '0;
    next_sub = 0;
    for (k = 0; k < DEPTH; k++) written[k] = 1'b0;

    // The last subspace gets a codebook with obvious winners: zero (twice, for the
    // tie), all +127, all -128, and small positive constants.
    for (k = 0; k < CODEWORDS; k++) begin
      case (k)
        0, 3: cw = '0;
        1: cw = {ELEMS{8'h7F}};
        2: cw = {ELEMS{8'h80}};
        default: cw = {ELEMS{ELEM_W'(k)}};
      endcase
      add_row(make_request(KIND_LOAD, SUB_W'(SUBSPACES - 1), IDX_W'(k), cw), 1'b0, none);
    end
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), '0, {ELEMS{8'h80}}), 1'b1,
            make_match(0, 0, 32'h0000_0000, 1'b1));
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), 4'hF, {ELEMS{8'hFF}}), 1'b1,
            make_match(1, -129032, 32'h1000_0000, 1'b1));
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), 4'h5, {ELEMS{8'h00}}), 1'b1,
            make_match(2, -131072, 32'h2000_0000, 1'b1));
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), '0, {4{8'hFF, 8'h00}}), 1'b0,
            none);
    add_row(make_request(KIND_LOAD, SUB_W'(SUBSPACES - 1), 4'h5, {4{8'hAA, 8'h55}}), 1'b0,
            none);
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), '0, {4{8'h00, 8'hFF}}), 1'b0,
            none);
    add_row(make_request(KIND_QUERY, SUB_W'(SUBSPACES - 1), '0, {4{8'h7F, 8'h81}}), 1'b0,
            none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      hold_off(gap_cycles(i + 50));
    end
    drain_results();

    for (k = 0; k < DEPTH; k++) begin
      sub  = SUB_W'(k / CODEWORDS);
      code = IDX_W'(k % CODEWORDS);
      send_request(make_request(KIND_LOAD, sub, code, codeword_for(sub)), 1'b0, none);
      hold_off(gap_cycles(k));
    end

    // Mostly whole vectors in subspace order, with stray subspaces and reloads mixed in.
    for (n = 0; n < MIXED_REQUESTS; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 99) < 80) sub = SUB_W'(next_sub);
        else sub = SUB_W'($urandom_range(0, SUBSPACES - 1));
        next_sub = (sub == SUBSPACES - 1) ? 0 : sub + 1;
        r = make_request(KIND_QUERY, sub, IDX_W'($urandom_range(0, CODEWORDS - 1)),
                         random_elems());
      end else begin
        sub  = SUB_W'($urandom_range(0, SUBSPACES - 1));
        code = IDX_W'($urandom_range(0, CODEWORDS - 1));
        r = make_request(KIND_LOAD, sub, code, codeword_for(sub));
      end
      send_request(r, 1'b0, none);
      if (n % 140 == 139) drain_results();
      else hold_off(gap_cycles(n));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    match_t want;
    if (rst_n && out_valid) begin
      if (pending_matches.size() == 0) begin
        $error("result with no request waiting: index %0d score %0d",
               out_best_index, out_best_score);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (out_best_index !== want.best_index) begin
          $error("best_index: expected %0d, got %0d", want.best_index, out_best_index);
          errors++;
        end
        if (out_best_score !== want.best_score) begin
          $error("best_score: expected %0d, got %0d", $signed(want.best_score),
                 out_best_score);
          errors++;
        end
        if (out_packed_word !== want.packed_word) begin
          $error("packed_word: expected %08h, got %08h", want.packed_word,
                 out_packed_word);
          errors++;
        end
        if (out_word_done !== want.word_done) begin
          $error("word_done: expected %0d, got %0d", want.word_done, out_word_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
